/* sv/bcsc_pkg.sv */
`default_nettype none

package bcsc_pkg;

	// Width of the width and height fields, 4 fraction bits
	localparam int DIM_BITS = 16;

	// Default coordinate width, 4 fraction bits
	localparam int COORD_BITS_DEF = 20;

	localparam int SIDE_BITS = 3;

	typedef enum logic [SIDE_BITS-1:0] {
		SIDE_NONE   = 3'd0,
		SIDE_RIGHT  = 3'd1,
		SIDE_LEFT   = 3'd2,
		SIDE_TOP    = 3'd3,
		SIDE_BOTTOM = 3'd4
	} side_t;

endpackage

`default_nettype wire

/* sv/box_collision_side_classifier.sv */
`default_nettype none

// Box contact side classifier.
// Give one pair of boxes per word on the command channel: a word is taken at
// the rising edge where start is high and busy is low. busy is tied low, so a
// new pair may be offered in every cycle and the block sustains one word per
// clock.
// Each pair yields exactly one result: contact_side is shown for a single
// cycle with done high once the word has passed the input capture register
// and the result register, and is taken by the receiver at the edge that
// ends that cycle. The path runs through two register stages: input capture,
// then the right and bottom edge sums and the pattern compare network into
// the result register. The receiver cannot stall; results are not held, so it
// must take each one in the cycle that done is high.
// Coordinates are signed with 4 fraction bits, COORD_BITS wide; widths and
// heights are unsigned 16-bit with 4 fraction bits. All sums and depths are
// exact.
// Reset (arst_n low) clears the valid flag and the result strobe, so no result
// appears from words in flight at reset; the data registers are not reset.
module box_collision_side_classifier #(
	parameter int COORD_BITS = bcsc_pkg::COORD_BITS_DEF
) (
	input  wire logic                             clk,
	input  wire logic                             arst_n,
	input  wire logic                             start,
	output logic                                  busy,
	input  wire logic signed [COORD_BITS-1:0]     first_left,
	input  wire logic signed [COORD_BITS-1:0]     first_top,
	input  wire logic [bcsc_pkg::DIM_BITS-1:0]    first_width,
	input  wire logic [bcsc_pkg::DIM_BITS-1:0]    first_height,
	input  wire logic signed [COORD_BITS-1:0]     second_left,
	input  wire logic signed [COORD_BITS-1:0]     second_top,
	input  wire logic [bcsc_pkg::DIM_BITS-1:0]    second_width,
	input  wire logic [bcsc_pkg::DIM_BITS-1:0]    second_height,
	output logic                                  done,
	output logic [bcsc_pkg::SIDE_BITS-1:0]        contact_side
);

	localparam int MAXB = (COORD_BITS > bcsc_pkg::DIM_BITS) ? COORD_BITS : bcsc_pkg::DIM_BITS;
	// Edge width: holds every right/bottom edge and every depth exactly
	localparam int EW = MAXB + 2;
	localparam int CX = EW - COORD_BITS;
	localparam int DX = EW - bcsc_pkg::DIM_BITS;

	logic accept;
	assign busy   = 1'b0;
	assign accept = start && !busy;

	// Stage 1: capture the input word
	logic                                valid_s1;
	logic signed [COORD_BITS-1:0]        l1_s1, t1_s1, l2_s1, t2_s1;
	logic [bcsc_pkg::DIM_BITS-1:0]       w1_s1, h1_s1, w2_s1, h2_s1;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s1 <= 1'b0;
		end else begin
			valid_s1 <= accept;
		end
	end

	always_ff @(posedge clk) begin
		if (accept) begin
			l1_s1 <= first_left;
			t1_s1 <= first_top;
			w1_s1 <= first_width;
			h1_s1 <= first_height;
			l2_s1 <= second_left;
			t2_s1 <= second_top;
			w2_s1 <= second_width;
			h2_s1 <= second_height;
		end
	end

	// Extend to edge width
	logic signed [EW-1:0] l1_x, t1_x, l2_x, t2_x;
	logic signed [EW-1:0] w1_x, h1_x, w2_x, h2_x;

	assign l1_x = {{CX{l1_s1[COORD_BITS-1]}}, l1_s1};
	assign t1_x = {{CX{t1_s1[COORD_BITS-1]}}, t1_s1};
	assign l2_x = {{CX{l2_s1[COORD_BITS-1]}}, l2_s1};
	assign t2_x = {{CX{t2_s1[COORD_BITS-1]}}, t2_s1};
	assign w1_x = {{DX{1'b0}}, w1_s1};
	assign h1_x = {{DX{1'b0}}, h1_s1};
	assign w2_x = {{DX{1'b0}}, w2_s1};
	assign h2_x = {{DX{1'b0}}, h2_s1};

	// Form right and bottom edges
	logic signed [EW-1:0] r1_x, b1_x, r2_x, b2_x;

	assign r1_x = l1_x + w1_x;
	assign b1_x = t1_x + h1_x;
	assign r2_x = l2_x + w2_x;
	assign b2_x = t2_x + h2_x;

	// Classify the pair
	bcsc_pkg::side_t side_c;

	bcsc_classify #(
		.EW (EW)
	) u_classify (
		.l1   (l1_x),
		.t1   (t1_x),
		.r1   (r1_x),
		.b1   (b1_x),
		.l2   (l2_x),
		.t2   (t2_x),
		.r2   (r2_x),
		.b2   (b2_x),
		.side (side_c)
	);

	// Result register: strobe for one cycle
	logic                          done_q;
	logic [bcsc_pkg::SIDE_BITS-1:0] side_q;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			done_q <= 1'b0;
		end else begin
			done_q <= valid_s1;
		end
	end

	always_ff @(posedge clk) begin
		if (valid_s1) begin
			side_q <= side_c;
		end
	end

	assign done         = done_q;
	assign contact_side = side_q;

endmodule

`default_nettype wire

/* sv/bcsc_classify.sv */
`default_nettype none

module bcsc_classify #(
	parameter int EW = 22
) (
	input  wire logic signed [EW-1:0] l1,
	input  wire logic signed [EW-1:0] t1,
	input  wire logic signed [EW-1:0] r1,
	input  wire logic signed [EW-1:0] b1,
	input  wire logic signed [EW-1:0] l2,
	input  wire logic signed [EW-1:0] t2,
	input  wire logic signed [EW-1:0] r2,
	input  wire logic signed [EW-1:0] b2,
	output bcsc_pkg::side_t           side
);

	// Penetration depths used by the tie-breaking patterns
	logic signed [EW-1:0] dep_b2t1;
	logic signed [EW-1:0] dep_b1t2;
	logic signed [EW-1:0] dep_r1l2;
	logic signed [EW-1:0] dep_r2l1;

	assign dep_b2t1 = b2 - t1;
	assign dep_b1t2 = b1 - t2;
	assign dep_r1l2 = r1 - l2;
	assign dep_r2l1 = r2 - l1;

	// Strict and non-strict edge orderings shared by the patterns
	logic h_a_lt, h_a_le, h_b_lt, h_b_le;
	logic v_a_lt, v_a_le, v_b_lt, v_b_le;
	logic hs_a, hs_b;
	logic vs_a, vs_b;

	// first box enters from the left / right
	assign h_a_lt = (l1 < l2) && (l2 < r1) && (r1 < r2);
	assign h_a_le = (l1 <= l2) && (l2 <= r1) && (r1 <= r2);
	assign h_b_lt = (l2 < l1) && (l1 < r2) && (r2 < r1);
	assign h_b_le = (l2 <= l1) && (l1 <= r2) && (r2 <= r1);
	// second box top inside first / first top inside second
	assign v_a_lt = (t1 < t2) && (t2 < b2) && (b2 < b1);
	assign v_a_le = (t1 <= t2) && (t2 <= b1) && (b1 <= b2);
	assign v_b_lt = (t2 < t1) && (t1 < b1) && (b1 < b2);
	assign v_b_le = (t2 <= t1) && (t1 <= b2) && (b2 <= b1);
	// vertical entries
	assign vs_a = (t2 < t1) && (t1 < b2) && (b2 < b1);
	assign vs_b = (t1 < t2) && (t2 < b1) && (b1 < b2);
	// horizontal spans
	assign hs_a = (l2 < l1) && (l1 < r1) && (r1 < r2);
	assign hs_b = (l1 < l2) && (l2 < r2) && (r2 < r1);

	// Take the first matching pattern in priority order
	always_comb begin
		side = bcsc_pkg::SIDE_NONE;
		if (h_a_lt && v_a_lt) begin
			side = bcsc_pkg::SIDE_RIGHT;
		end else if (h_a_lt && v_b_lt) begin
			side = bcsc_pkg::SIDE_RIGHT;
		end else if (h_a_le && v_b_le) begin
			side = (dep_b2t1 > dep_r1l2) ? bcsc_pkg::SIDE_RIGHT : bcsc_pkg::SIDE_TOP;
		end else if (h_a_le && v_a_le) begin
			side = (dep_b1t2 > dep_r1l2) ? bcsc_pkg::SIDE_RIGHT : bcsc_pkg::SIDE_BOTTOM;
		end else if (h_b_lt && v_a_lt) begin
			side = bcsc_pkg::SIDE_LEFT;
		end else if (h_b_lt && v_b_lt) begin
			side = bcsc_pkg::SIDE_LEFT;
		end else if (h_b_le && v_b_le) begin
			side = (dep_b2t1 > dep_r2l1) ? bcsc_pkg::SIDE_LEFT : bcsc_pkg::SIDE_TOP;
		end else if (h_b_le && v_a_le) begin
			side = (dep_b1t2 > dep_r2l1) ? bcsc_pkg::SIDE_LEFT : bcsc_pkg::SIDE_BOTTOM;
		end else if (vs_a && hs_a) begin
			side = bcsc_pkg::SIDE_TOP;
		end else if (vs_a && hs_b) begin
			side = bcsc_pkg::SIDE_TOP;
		end else if (vs_b && hs_a) begin
			side = bcsc_pkg::SIDE_BOTTOM;
		end else if (vs_b && hs_b) begin
			side = bcsc_pkg::SIDE_BOTTOM;
		end
	end

endmodule

`default_nettype wire
